[rtl/ptg_pkg.sv]
package ptg_pkg;

    localparam int PTG_DIM_BITS  = 22;
    localparam int PTG_TILE_BITS = 12;
    localparam int RES_W         = 5;
    localparam int IDX_W         = 32;
    localparam int ZOOM_W        = 5;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int RESET_DIM     = 256;
    localparam int RESET_TILE    = 256;

    typedef enum logic [1:0] {
        REG_BASE_W = 2'd0,
        REG_BASE_H = 2'd1,
        REG_TILE_W = 2'd2,
        REG_TILE_H = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RES  = 2'd1,
        ST_BAD_TILE = 2'd2
    } t_status;

    typedef struct packed {
        logic              bad_res;
        logic              bad_tile;
        logic [ZOOM_W-1:0] zoom;
    } t_tag;

endpackage

[rtl/pyramid_tile_geometry_top.sv]
// channel   direction  handshake              word
// request   in         i_valid / o_ready      i_resolution, i_tile_index
// result    out        o_valid / i_ready      o_status .. o_byte_count
// config    in         APB psel/penable/...   base_width, base_height, tile_w, tile_h
//
// Fully pipelined: one request per cycle while the result is not stalled,
// through the bit-serial divider pipelines (layer/tile, then index/columns).
// Synchronous active-low reset clears valid bits and loads config defaults.
// A stalled result freezes every stage; o_ready is low only while the
// output word waits.
module pyramid_tile_geometry_top
    import ptg_pkg::*;
#(
    parameter int DIM_BITS  = PTG_DIM_BITS,
    parameter int TILE_BITS = PTG_TILE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [RES_W-1:0]       i_resolution,
    input  logic [IDX_W-1:0]       i_tile_index,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic [TILE_BITS:0]     o_out_tile_w,
    output logic [TILE_BITS:0]     o_out_tile_h,
    output logic [DIM_BITS-1:0]    o_base_x,
    output logic [DIM_BITS-1:0]    o_base_y,
    output logic [ZOOM_W-1:0]      o_zoom_step,
    output logic [2*TILE_BITS+1:0] o_byte_count,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int TW   = TILE_BITS + 1;
    localparam int P1W  = $bits(t_tag) + IDX_W;
    localparam int P2W  = $bits(t_tag) + 2 * DIM_BITS + 2 * TW;

    logic [DIM_BITS-1:0] r_base_w;
    logic [DIM_BITS-1:0] r_base_h;
    logic [TW-1:0]       r_tile_w;
    logic [TW-1:0]       r_tile_h;

    logic [TW-1:0]       tw_c;
    logic [TW-1:0]       th_c;
    logic                en;
    t_reg_idx            ridx;

    logic                f_valid;
    t_tag                f_tag;
    logic [IDX_W-1:0]    f_tile;
    logic [DIM_BITS-1:0] f_lw;
    logic [DIM_BITS-1:0] f_lh;

    logic                d1_valid;
    logic [DIM_BITS-1:0] d1_qx;
    logic [DIM_BITS-1:0] d1_qy;
    logic [TW-1:0]       d1_rx;
    logic [TW-1:0]       d1_ry;
    logic [P1W-1:0]      d1_pay;
    t_tag                d1_tag;
    logic [IDX_W-1:0]    d1_tile;

    logic                c_valid;
    t_tag                c_tag;
    logic [IDX_W-1:0]    c_tile;
    logic [DIM_BITS-1:0] c_ncol;
    logic [DIM_BITS-1:0] c_nrow;
    logic [TW-1:0]       c_rx;
    logic [TW-1:0]       c_ry;

    logic                d2_valid;
    logic [IDX_W-1:0]    d2_row;
    logic [DIM_BITS-1:0] d2_col;
    logic [P2W-1:0]      d2_pay;
    t_tag                d2_tag;
    logic [DIM_BITS-1:0] d2_ncol;
    logic [DIM_BITS-1:0] d2_nrow;
    logic [TW-1:0]       d2_rx;
    logic [TW-1:0]       d2_ry;

    // config port
    assign pready = 1'b1;
    assign ridx   = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_w <= DIM_BITS'(RESET_DIM);
            r_base_h <= DIM_BITS'(RESET_DIM);
            r_tile_w <= TW'(RESET_TILE);
            r_tile_h <= TW'(RESET_TILE);
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_BASE_W: r_base_w <= pwdata[DIM_BITS-1:0];
                REG_BASE_H: r_base_h <= pwdata[DIM_BITS-1:0];
                REG_TILE_W: r_tile_w <= pwdata[TW-1:0];
                REG_TILE_H: r_tile_h <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_BASE_W: prdata = DATA_W'(r_base_w);
            REG_BASE_H: prdata = DATA_W'(r_base_h);
            REG_TILE_W: prdata = DATA_W'(r_tile_w);
            REG_TILE_H: prdata = DATA_W'(r_tile_h);
            default:    prdata = '0;
        endcase
    end

    // zero tile size acts as 1, oversize clamps to the max tile
    always_comb begin
        if (r_tile_w == '0) begin
            tw_c = TW'(1);
        end else if (r_tile_w > (TW'(1) << TILE_BITS)) begin
            tw_c = TW'(1) << TILE_BITS;
        end else begin
            tw_c = r_tile_w;
        end
        if (r_tile_h == '0) begin
            th_c = TW'(1);
        end else if (r_tile_h > (TW'(1) << TILE_BITS)) begin
            th_c = TW'(1) << TILE_BITS;
        end else begin
            th_c = r_tile_h;
        end
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    ptg_front #(
        .DIM_BITS  (DIM_BITS),
        .TILE_BITS (TILE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_res    (i_resolution),
        .i_tile   (i_tile_index),
        .i_base_w (r_base_w),
        .i_base_h (r_base_h),
        .i_tw     (tw_c),
        .i_th     (th_c),
        .o_valid  (f_valid),
        .o_tag    (f_tag),
        .o_tile   (f_tile),
        .o_lw     (f_lw),
        .o_lh     (f_lh)
    );

    ptg_div #(
        .NW (DIM_BITS),
        .DW (TW),
        .PW (P1W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num   (f_lw),
        .i_den   (tw_c),
        .i_pay   ({f_tag, f_tile}),
        .o_valid (d1_valid),
        .o_quo   (d1_qx),
        .o_rem   (d1_rx),
        .o_pay   (d1_pay)
    );

    ptg_div #(
        .NW (DIM_BITS),
        .DW (TW),
        .PW (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num   (f_lh),
        .i_den   (th_c),
        .i_pay   (1'b0),
        .o_valid (),
        .o_quo   (d1_qy),
        .o_rem   (d1_ry),
        .o_pay   ()
    );

    assign {d1_tag, d1_tile} = d1_pay;

    ptg_count #(
        .DIM_BITS  (DIM_BITS),
        .TILE_BITS (TILE_BITS)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d1_valid),
        .i_tag   (d1_tag),
        .i_tile  (d1_tile),
        .i_qx    (d1_qx),
        .i_rx    (d1_rx),
        .i_qy    (d1_qy),
        .i_ry    (d1_ry),
        .o_valid (c_valid),
        .o_tag   (c_tag),
        .o_tile  (c_tile),
        .o_ncol  (c_ncol),
        .o_nrow  (c_nrow),
        .o_rx    (c_rx),
        .o_ry    (c_ry)
    );

    ptg_div #(
        .NW (IDX_W),
        .DW (DIM_BITS),
        .PW (P2W)
    ) u_div_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid),
        .i_num   (c_tile),
        .i_den   (c_ncol),
        .i_pay   ({c_tag, c_ncol, c_nrow, c_rx, c_ry}),
        .o_valid (d2_valid),
        .o_quo   (d2_row),
        .o_rem   (d2_col),
        .o_pay   (d2_pay)
    );

    assign {d2_tag, d2_ncol, d2_nrow, d2_rx, d2_ry} = d2_pay;

    ptg_back #(
        .DIM_BITS  (DIM_BITS),
        .TILE_BITS (TILE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d2_valid),
        .i_tag    (d2_tag),
        .i_row    (d2_row),
        .i_col    (d2_col),
        .i_ncol   (d2_ncol),
        .i_nrow   (d2_nrow),
        .i_rx     (d2_rx),
        .i_ry     (d2_ry),
        .i_tw     (tw_c),
        .i_th     (th_c),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_tile_w (o_out_tile_w),
        .o_tile_h (o_out_tile_h),
        .o_base_x (o_base_x),
        .o_base_y (o_base_y),
        .o_zoom   (o_zoom_step),
        .o_bytes  (o_byte_count)
    );

endmodule

[rtl/ptg_div.sv]
module ptg_div
    import ptg_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 22,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);

    // one quotient bit per stage, restoring
    logic [NW-1:0] r_v;
    logic [NW-1:0] r_n [NW];
    logic [DW-1:0] r_r [NW];
    logic [DW-1:0] r_d [NW];
    logic [PW-1:0] r_p [NW];

    logic [NW-1:0] n_v;
    logic [NW-1:0] n_n [NW];
    logic [DW-1:0] n_r [NW];
    logic [DW-1:0] n_d [NW];
    logic [PW-1:0] n_p [NW];

    always_comb begin
        logic          sv;
        logic [NW-1:0] sn;
        logic [DW-1:0] sr;
        logic [DW-1:0] sd;
        logic [PW-1:0] sp;
        logic [DW:0]   t;
        logic          ge;
        for (int s = 0; s < NW; s++) begin
            if (s == 0) begin
                sv = i_valid;
                sn = i_num;
                sr = '0;
                sd = i_den;
                sp = i_pay;
            end else begin
                sv = r_v[s-1];
                sn = r_n[s-1];
                sr = r_r[s-1];
                sd = r_d[s-1];
                sp = r_p[s-1];
            end
            t  = {sr, sn[NW-1]};
            ge = (t >= {1'b0, sd});
            n_v[s] = sv;
            n_n[s] = {sn[NW-2:0], ge};
            n_r[s] = ge ? DW'(t - {1'b0, sd}) : DW'(t);
            n_d[s] = sd;
            n_p[s] = sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
        if (i_en) begin
            for (int s = 0; s < NW; s++) begin
                r_n[s] <= n_n[s];
                r_r[s] <= n_r[s];
                r_d[s] <= n_d[s];
                r_p[s] <= n_p[s];
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_n[NW-1];
    assign o_rem   = r_r[NW-1];
    assign o_pay   = r_p[NW-1];

endmodule

[rtl/ptg_front.sv]
module ptg_front
    import ptg_pkg::*;
#(
    parameter int DIM_BITS  = PTG_DIM_BITS,
    parameter int TILE_BITS = PTG_TILE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RES_W-1:0]     i_res,
    input  logic [IDX_W-1:0]     i_tile,
    input  logic [DIM_BITS-1:0]  i_base_w,
    input  logic [DIM_BITS-1:0]  i_base_h,
    input  logic [TILE_BITS:0]   i_tw,
    input  logic [TILE_BITS:0]   i_th,
    output logic                 o_valid,
    output t_tag                 o_tag,
    output logic [IDX_W-1:0]     o_tile,
    output logic [DIM_BITS-1:0]  o_lw,
    output logic [DIM_BITS-1:0]  o_lh
);

    localparam int TW = TILE_BITS + 1;
    localparam int CW = (DIM_BITS > TW) ? DIM_BITS : TW;
    localparam int NK = 1 << ZOOM_W;

    logic                r1_valid;
    logic [RES_W-1:0]    r1_res;
    logic [IDX_W-1:0]    r1_tile;
    logic [ZOOM_W-1:0]   r1_kmin;
    logic [ZOOM_W-1:0]   n_kmin;

    logic                r2_valid;
    t_tag                r2_tag;
    logic [IDX_W-1:0]    r2_tile;
    logic [DIM_BITS-1:0] r2_lw;
    logic [DIM_BITS-1:0] r2_lh;
    t_tag                n_tag;

    // fewest halvings that fit one tile = level count - 1
    always_comb begin
        logic fit;
        n_kmin = ZOOM_W'(NK - 1);
        for (int k = NK - 1; k >= 0; k--) begin
            fit = (CW'(i_base_w >> k) <= CW'(i_tw)) && (CW'(i_base_h >> k) <= CW'(i_th));
            if (fit) begin
                n_kmin = ZOOM_W'(k);
            end
        end
    end

    always_comb begin
        n_tag.bad_res  = (r1_res > r1_kmin);
        n_tag.bad_tile = 1'b0;
        n_tag.zoom     = r1_kmin - r1_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r1_res  <= i_res;
            r1_tile <= i_tile;
            r1_kmin <= n_kmin;
            r2_tag  <= n_tag;
            r2_tile <= r1_tile;
            r2_lw   <= i_base_w >> n_tag.zoom;
            r2_lh   <= i_base_h >> n_tag.zoom;
        end
    end

    assign o_valid = r2_valid;
    assign o_tag   = r2_tag;
    assign o_tile  = r2_tile;
    assign o_lw    = r2_lw;
    assign o_lh    = r2_lh;

endmodule

[rtl/ptg_count.sv]
module ptg_count
    import ptg_pkg::*;
#(
    parameter int DIM_BITS  = PTG_DIM_BITS,
    parameter int TILE_BITS = PTG_TILE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_tag                 i_tag,
    input  logic [IDX_W-1:0]     i_tile,
    input  logic [DIM_BITS-1:0]  i_qx,
    input  logic [TILE_BITS:0]   i_rx,
    input  logic [DIM_BITS-1:0]  i_qy,
    input  logic [TILE_BITS:0]   i_ry,
    output logic                 o_valid,
    output t_tag                 o_tag,
    output logic [IDX_W-1:0]     o_tile,
    output logic [DIM_BITS-1:0]  o_ncol,
    output logic [DIM_BITS-1:0]  o_nrow,
    output logic [TILE_BITS:0]   o_rx,
    output logic [TILE_BITS:0]   o_ry
);

    localparam int PW2 = (2 * DIM_BITS > IDX_W) ? 2 * DIM_BITS : IDX_W;

    logic                  r3_valid;
    t_tag                  r3_tag;
    logic [IDX_W-1:0]      r3_tile;
    logic [DIM_BITS-1:0]   r3_ncol;
    logic [DIM_BITS-1:0]   r3_nrow;
    logic [TILE_BITS:0]    r3_rx;
    logic [TILE_BITS:0]    r3_ry;

    logic                  r4_valid;
    t_tag                  r4_tag;
    logic [IDX_W-1:0]      r4_tile;
    logic [DIM_BITS-1:0]   r4_ncol;
    logic [DIM_BITS-1:0]   r4_nrow;
    logic [TILE_BITS:0]    r4_rx;
    logic [TILE_BITS:0]    r4_ry;
    logic [2*DIM_BITS-1:0] r4_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r3_tag   <= i_tag;
            r3_tile  <= i_tile;
            r3_ncol  <= i_qx + DIM_BITS'(i_rx != '0);
            r3_nrow  <= i_qy + DIM_BITS'(i_ry != '0);
            r3_rx    <= i_rx;
            r3_ry    <= i_ry;
            r4_tag   <= r3_tag;
            r4_tile  <= r3_tile;
            r4_ncol  <= r3_ncol;
            r4_nrow  <= r3_nrow;
            r4_rx    <= r3_rx;
            r4_ry    <= r3_ry;
            r4_total <= r3_ncol * r3_nrow;
        end
    end

    always_comb begin
        o_tag          = r4_tag;
        o_tag.bad_tile = (r4_ncol == '0) || (r4_nrow == '0)
                       || (PW2'(r4_tile) >= PW2'(r4_total));
    end

    assign o_valid = r4_valid;
    assign o_tile  = r4_tile;
    assign o_ncol  = r4_ncol;
    assign o_nrow  = r4_nrow;
    assign o_rx    = r4_rx;
    assign o_ry    = r4_ry;

endmodule

[rtl/ptg_back.sv]
module ptg_back
    import ptg_pkg::*;
#(
    parameter int DIM_BITS  = PTG_DIM_BITS,
    parameter int TILE_BITS = PTG_TILE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_tag                   i_tag,
    input  logic [IDX_W-1:0]       i_row,
    input  logic [DIM_BITS-1:0]    i_col,
    input  logic [DIM_BITS-1:0]    i_ncol,
    input  logic [DIM_BITS-1:0]    i_nrow,
    input  logic [TILE_BITS:0]     i_rx,
    input  logic [TILE_BITS:0]     i_ry,
    input  logic [TILE_BITS:0]     i_tw,
    input  logic [TILE_BITS:0]     i_th,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [TILE_BITS:0]     o_tile_w,
    output logic [TILE_BITS:0]     o_tile_h,
    output logic [DIM_BITS-1:0]    o_base_x,
    output logic [DIM_BITS-1:0]    o_base_y,
    output logic [ZOOM_W-1:0]      o_zoom,
    output logic [2*TILE_BITS+1:0] o_bytes
);

    localparam int TW = TILE_BITS + 1;
    localparam int PXW = DIM_BITS + TW;
    localparam int BW = 2 * TW;

    logic                r6_valid;
    t_tag                r6_tag;
    logic [TW-1:0]       r6_aw;
    logic [TW-1:0]       r6_ah;
    logic [PXW-1:0]      r6_px;
    logic [PXW-1:0]      r6_py;

    logic                r7_valid;
    t_tag                r7_tag;
    logic [TW-1:0]       r7_aw;
    logic [TW-1:0]       r7_ah;
    logic [DIM_BITS-1:0] r7_bx;
    logic [DIM_BITS-1:0] r7_by;
    logic [BW-1:0]       r7_area;

    logic                r_valid;
    t_status             r_status;
    logic [TW-1:0]       r_aw;
    logic [TW-1:0]       r_ah;
    logic [DIM_BITS-1:0] r_bx;
    logic [DIM_BITS-1:0] r_by;
    logic [ZOOM_W-1:0]   r_zoom;
    logic [BW-1:0]       r_bytes;

    logic [DIM_BITS-1:0] row;
    logic                last_col;
    logic                last_row;
    logic                err;
    t_status             n_status;

    assign row      = i_row[DIM_BITS-1:0];
    assign last_col = (i_col == i_ncol - 1'b1) && (i_rx != '0);
    assign last_row = (row == i_nrow - 1'b1) && (i_ry != '0);
    assign err      = r7_tag.bad_res || r7_tag.bad_tile;

    always_comb begin
        if (r7_tag.bad_res) begin
            n_status = ST_BAD_RES;
        end else if (r7_tag.bad_tile) begin
            n_status = ST_BAD_TILE;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_en) begin
            r6_valid <= i_valid;
            r7_valid <= r6_valid;
            r_valid  <= r7_valid;
        end
        if (i_en) begin
            r6_tag   <= i_tag;
            r6_aw    <= last_col ? i_rx : i_tw;
            r6_ah    <= last_row ? i_ry : i_th;
            r6_px    <= i_col * i_tw;
            r6_py    <= row * i_th;
            r7_tag   <= r6_tag;
            r7_aw    <= r6_aw;
            r7_ah    <= r6_ah;
            r7_bx    <= r6_px[DIM_BITS-1:0] << r6_tag.zoom;
            r7_by    <= r6_py[DIM_BITS-1:0] << r6_tag.zoom;
            r7_area  <= r6_aw * r6_ah;
            r_status <= n_status;
            r_aw     <= err ? '0 : r7_aw;
            r_ah     <= err ? '0 : r7_ah;
            r_bx     <= err ? '0 : r7_bx;
            r_by     <= err ? '0 : r7_by;
            r_zoom   <= err ? '0 : r7_tag.zoom;
            r_bytes  <= err ? '0 : BW'({r7_area, 1'b0} + {1'b0, r7_area});
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_tile_w = r_aw;
    assign o_tile_h = r_ah;
    assign o_base_x = r_bx;
    assign o_base_y = r_by;
    assign o_zoom   = r_zoom;
    assign o_bytes  = r_bytes;

endmodule

[verif/tb_pyramid_tile_geometry_top.sv]
`timescale 1ns / 100ps

module tb_pyramid_tile_geometry_top;
    import ptg_pkg::*;

    localparam int LATENCY   = PTG_DIM_BITS + 32 + 7;
    localparam int WDOG_MAX  = 20000;
    localparam int TMAX      = 1 << PTG_TILE_BITS;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic [IDX_W-1:0] idx;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [PTG_TILE_BITS:0]   tw;
        logic [PTG_TILE_BITS:0]   th;
        logic [PTG_DIM_BITS-1:0]  bx;
        logic [PTG_DIM_BITS-1:0]  by;
        logic [ZOOM_W-1:0]        zoom;
        logic [2*PTG_TILE_BITS+1:0] bytes;
    } t_geom;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [RES_W-1:0] i_resolution = '0;
    logic [IDX_W-1:0] i_tile_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_status;
    logic [PTG_TILE_BITS:0] o_out_tile_w, o_out_tile_h;
    logic [PTG_DIM_BITS-1:0] o_base_x, o_base_y;
    logic [ZOOM_W-1:0] o_zoom_step;
    logic [2*PTG_TILE_BITS+1:0] o_byte_count;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pyramid_tile_geometry_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint unsigned cfg_bw = RESET_DIM, cfg_bh = RESET_DIM;
    longint unsigned cfg_tw = RESET_TILE, cfg_th = RESET_TILE;

    t_req  pending_reqs[$];
    t_geom expected_geom[$];
    int    send_idle_pct = 0, recv_idle_pct = 0;
    int    errors = 0, n_sent = 0, n_recv = 0, wdog = 0;

    function automatic longint unsigned clamp_tile(longint unsigned t);
        if (t == 0) return 1;
        if (t > TMAX) return TMAX;
        return t;
    endfunction

    function automatic longint unsigned level_count(longint unsigned tw, longint unsigned th);
        longint unsigned w = cfg_bw, h = cfg_bh, n = 1;
        while (w > tw || h > th) begin
            w >>= 1;
            h >>= 1;
            n++;
        end
        return n;
    endfunction

    function automatic t_geom tile_geometry(t_req r);
        t_geom g;
        longint unsigned tw, th, lv, zoom, lw, lh, rx, ry, ncol, nrow, col, row, aw, ah;
        g = '0;
        tw = clamp_tile(cfg_tw);
        th = clamp_tile(cfg_th);
        lv = level_count(tw, th);
        if (r.res >= lv) begin
            g.status = ST_BAD_RES;
            return g;
        end
        zoom = lv - 1 - r.res;
        lw = cfg_bw >> zoom;
        lh = cfg_bh >> zoom;
        rx = lw % tw;
        ry = lh % th;
        ncol = lw / tw + (rx != 0);
        nrow = lh / th + (ry != 0);
        if (ncol == 0 || nrow == 0 || r.idx >= ncol * nrow) begin
            g.status = ST_BAD_TILE;
            return g;
        end
        col = r.idx % ncol;
        row = r.idx / ncol;
        aw = (col == ncol - 1 && rx != 0) ? rx : tw;
        ah = (row == nrow - 1 && ry != 0) ? ry : th;
        g.status = ST_OK;
        g.tw = aw;
        g.th = ah;
        g.bx = (col * tw) << zoom;
        g.by = (row * th) << zoom;
        g.zoom = zoom;
        g.bytes = aw * ah * 3;
        return g;
    endfunction

    // number of tiles in a level, 0 when resolution is out of range
    function automatic longint unsigned tiles_in_level(int res);
        longint unsigned tw, th, lv, lw, lh;
        tw = clamp_tile(cfg_tw);
        th = clamp_tile(cfg_th);
        lv = level_count(tw, th);
        if (res >= lv) return 0;
        lw = cfg_bw >> (lv - 1 - res);
        lh = cfg_bh >> (lv - 1 - res);
        return ((lw + tw - 1) / tw) * ((lh + th - 1) / th);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_geom = {expected_geom, tile_geometry({i_resolution, i_tile_index})};
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_resolution <= r.res;
                    i_tile_index <= r.idx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                t_geom got, exp_g;
                got = '{t_status'(o_status), o_out_tile_w, o_out_tile_h, o_base_x,
                        o_base_y, o_zoom_step, o_byte_count};
                n_recv++;
                if (expected_geom.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors++;
                end else begin
                    exp_g = expected_geom.pop_front();
                    if (got !== exp_g) begin
                        $display("%0t: mismatch exp st=%0d w=%0d h=%0d x=%0d y=%0d z=%0d b=%0d",
                                 $time, exp_g.status, exp_g.tw, exp_g.th, exp_g.bx,
                                 exp_g.by, exp_g.zoom, exp_g.bytes);
                        $display("%0t:          got st=%0d w=%0d h=%0d x=%0d y=%0d z=%0d b=%0d",
                                 $time, got.status, got.tw, got.th, got.bx,
                                 got.by, got.zoom, got.bytes);
                        errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n ||
            (pending_reqs.size() == 0 && expected_geom.size() == 0)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(t_reg_idx r, longint unsigned v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * r);
        pwdata <= DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_BASE_W: cfg_bw = v & 32'h3FFFFF;
            REG_BASE_H: cfg_bh = v & 32'h3FFFFF;
            REG_TILE_W: cfg_tw = v & 32'h1FFF;
            REG_TILE_H: cfg_th = v & 32'h1FFF;
            default: ;
        endcase
    endtask

    task automatic configure(longint unsigned bw, longint unsigned bh,
                             longint unsigned tw, longint unsigned th);
        write_reg(REG_BASE_W, bw);
        write_reg(REG_BASE_H, bh);
        write_reg(REG_TILE_W, tw);
        write_reg(REG_TILE_H, th);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_geom.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic add_req(int unsigned res, longint unsigned idx);
        t_req r;
        r.res = RES_W'(res);
        r.idx = IDX_W'(idx);
        pending_reqs = {pending_reqs, r};
    endtask

    // mostly well-formed requests in range, rest noise
    task automatic add_random(int n);
        t_req r;
        longint unsigned nt;
        for (int k = 0; k < n; k++) begin
            r.res = $urandom_range(31);
            if ($urandom_range(9) < 8) r.res = $urandom_range(4);
            nt = tiles_in_level(r.res);
            case ($urandom_range(9))
                0: r.idx = $urandom;
                1: r.idx = nt;
                2: r.idx = (nt > 0) ? nt - 1 : 0;
                default: r.idx = (nt > 0) ? $urandom_range(nt - 1) : $urandom_range(3);
            endcase
            pending_reqs = {pending_reqs, r};
        end
    endtask

    task automatic run_phase(int sp, int rp, int n);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        add_random(n);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset config
        add_req(0, 0);
        add_req(0, 1);
        add_req(1, 0);
        add_req(31, 0);
        add_req(0, 32'hFFFFFFFF);
        drain();

        // remainder tiles, clamp to max tile, extremes
        configure(1000, 700, 300, 200);
        for (int k = 0; k < 6; k++) add_req(2, k * 3);
        add_req(2, 15);
        add_req(3, 0);
        drain();
        configure(22'h3FFFFF, 22'h3FFFFF, 8191, 0);
        add_req(0, 0);
        add_req(31, 32'hFFFFFFFF);
        add_req(21, 32'h5555);
        add_req(22, 32'hAAAAAAAA);
        add_req(10, 1023);
        drain();
        configure(0, 5000, 4096, 1);
        add_req(0, 0);
        add_req(5, 0);
        drain();

        configure(4096, 4096, 4096, 4096);
        add_req(0, 0);
        add_req(0, 1);
        drain();

        configure(5000, 3000, 256, 256);
        run_phase(26, 52, 120);
        configure(777, 12345, 100, 64);
        run_phase(26, 52, 120);
        configure($urandom_range(22'h3FFFFF), $urandom_range(22'h3FFFFF),
                  $urandom_range(8191), $urandom_range(8191));
        run_phase(52, 26, 120);
        configure(1920, 1080, 1, 4096);
        run_phase(52, 26, 130);
        configure($urandom_range(3000), $urandom_range(3000),
                  $urandom_range(1, 64), $urandom_range(1, 64));
        run_phase(0, 0, 130);
        configure(22'h3FFFFF, 1, 4096, 4096);
        run_phase(0, 0, 110);

        $display("Covered %0d requests over several pyramid and tile configurations,", n_sent);
        $display("%0d result words checked, %0d errors.", n_recv, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
